/* sv/b64e_pkg.sv */
`default_nettype none

package b64e_pkg;

	localparam int QDepth = 2;
	localparam int QPtrW = $clog2(QDepth);
	localparam int QCntW = $clog2(QDepth + 1);

	localparam logic [7:0] PadChar = 8'h3D;
	localparam logic [7:0] PlusChar = 8'h2B;
	localparam logic [7:0] SlashChar = 8'h2F;
	localparam logic [7:0] UpperBase = 8'h41;
	localparam logic [7:0] LowerBase = 8'h61;
	localparam logic [7:0] DigitBase = 8'h30;

	localparam logic [1:0] LastCharIdx = 2'd3;
	localparam logic [1:0] FullGroupCnt = 2'd2;

	typedef struct packed {
		logic [23:0] group;
		logic [1:0]  pad_cnt;
		logic        last;
	} b64e_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} b64e_q_status_t;

	function automatic logic [7:0] map_sextet(input logic [5:0] s);
		logic [7:0] s8;
		logic [7:0] ch;
		s8 = {2'b00, s};
		if (s8 < 8'd26)
			ch = s8 + UpperBase;
		else if (s8 < 8'd52)
			ch = s8 - 8'd26 + LowerBase;
		else if (s8 < 8'd62)
			ch = s8 - 8'd52 + DigitBase;
		else if (s8 == 8'd62)
			ch = PlusChar;
		else
			ch = SlashChar;
		return ch;
	endfunction

endpackage

`default_nettype wire

/* sv/b64e_front.sv */
`default_nettype none

module b64e_front import b64e_pkg::*; (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic [7:0]     data_byte,
	input  wire logic           end_of_message,
	input  wire b64e_q_status_t q_st,
	output logic                push,
	output b64e_entry_t         push_entry
);

	logic [15:0] pending_q;
	logic [1:0]  count_q;
	logic        accept;

	assign in_ready = !q_st.full;
	assign accept = in_valid && in_ready;

	always_comb begin
		push_entry.last = end_of_message;
		if (count_q == FullGroupCnt) begin
			push_entry.group = {pending_q, data_byte};
			push_entry.pad_cnt = 2'd0;
		end else if (count_q == 2'd0) begin
			push_entry.group = {data_byte, 16'h0000};
			push_entry.pad_cnt = 2'd2;
		end else begin
			push_entry.group = {pending_q[7:0], data_byte, 8'h00};
			push_entry.pad_cnt = 2'd1;
		end
		push = accept && (count_q == FullGroupCnt || end_of_message);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			pending_q <= 16'h0000;
		end else if (accept) begin
			if (push) begin
				count_q <= 2'd0;
			end else begin
				pending_q <= {pending_q[7:0], data_byte};
				count_q <= count_q + 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

/* sv/b64e_queue.sv */
`default_nettype none

module b64e_queue import b64e_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire b64e_entry_t push_entry,
	input  wire logic        pop,
	output b64e_entry_t      pop_entry,
	output b64e_q_status_t   q_st
);

	b64e_entry_t      mem_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QCntW-1:0] cnt_q;

	assign q_st.full = (cnt_q == QCntW'(QDepth));
	assign q_st.empty = (cnt_q == '0);
	assign pop_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

/* sv/b64e_back.sv */
`default_nettype none

module b64e_back import b64e_pkg::*; (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire b64e_q_status_t q_st,
	input  wire b64e_entry_t    pop_entry,
	output logic                pop,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic [7:0]          out_char,
	output logic                last_char
);

	b64e_entry_t cur_q;
	logic        cur_valid_q;
	logic [1:0]  idx_q;
	logic        out_valid_q;
	logic [7:0]  out_char_q;
	logic        last_char_q;
	logic        out_free;
	logic        emit;
	logic        group_done;
	logic [5:0]  sextet;
	logic        is_pad;
	logic [7:0]  next_char;

	assign out_valid = out_valid_q;
	assign out_char = out_char_q;
	assign last_char = last_char_q;

	always_comb begin
		out_free = !out_valid_q || out_ready;
		emit = cur_valid_q && out_free;
		group_done = emit && (idx_q == LastCharIdx);
		pop = !q_st.empty && (!cur_valid_q || group_done);
		case (idx_q)
			2'd0: sextet = cur_q.group[23:18];
			2'd1: sextet = cur_q.group[17:12];
			2'd2: sextet = cur_q.group[11:6];
			default: sextet = cur_q.group[5:0];
		endcase
		is_pad = ({1'b0, idx_q} + {1'b0, cur_q.pad_cnt}) > 3'd3;
		next_char = is_pad ? PadChar : map_sextet(sextet);
	end

	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= pop_entry;
		if (emit) begin
			out_char_q <= next_char;
			last_char_q <= cur_q.last && (idx_q == LastCharIdx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
				idx_q <= 2'd0;
			end else if (emit) begin
				idx_q <= idx_q + 2'd1;
				if (group_done)
					cur_valid_q <= 1'b0;
			end
			if (out_free)
				out_valid_q <= cur_valid_q;
		end
	end

endmodule

`default_nettype wire

/* sv/base64_stream_encoder_unit.sv */
// Base64 stream encoder: one message byte per word in, one character per word out.
// The closing byte of a group goes through the group queue, the current-group register
// and the output register. One byte per cycle in while the queue is not full, one
// character per cycle out while out_ready holds; the output side limits a long run.
// Reset clears the pending byte count, the group queue and the output valid.
`default_nettype none

module base64_stream_encoder_unit import b64e_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       end_of_message,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_char,
	output logic            last_char
);

	b64e_q_status_t q_st;
	b64e_entry_t    push_entry;
	b64e_entry_t    pop_entry;
	logic           push;
	logic           pop;

	b64e_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.end_of_message (end_of_message),
		.q_st           (q_st),
		.push           (push),
		.push_entry     (push_entry)
	);

	b64e_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.q_st       (q_st)
	);

	b64e_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_st      (q_st),
		.pop_entry (pop_entry),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_char  (out_char),
		.last_char (last_char)
	);

endmodule

`default_nettype wire
